// File: src/nmed_pkg.sv
// nmed_pkg: shared types and constants of the neighbour mean equality detector
// no dependencies; used by nmed_front, nmed_back and the top level
package nmed_pkg;

   localparam int ROW_BITS      = 16;
   localparam int COL_BITS      = 10;
   localparam int TOTAL_BITS    = 26;
   localparam int ROWS_CFG_BITS = 16;
   localparam int COLS_CFG_BITS = 11;
   localparam int CSR_DATA_BITS = 16;

   // result kinds, in the order they leave for one request
   localparam int RES_UP     = 0;
   localparam int RES_LEFT   = 1;
   localparam int RES_CORNER = 2;
   localparam int RES_TOTAL  = 3;
   localparam int RES_KINDS  = 4;

   typedef enum logic {
      CSR_FRAME_ROWS = 1'b0,
      CSR_FRAME_COLS = 1'b1
   } nmed_csr_type;

   // position and test selection of one request, front to back
   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                up_cell;
      logic                low_left;
      logic                low_corner;
   } nmed_tag_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
      logic                  is_total;
      logic [TOTAL_BITS-1:0] total;
      logic                  last;
   } nmed_rsp_type;

endpackage

// File: src/nmed_ram.sv
// nmed_ram: generic single write port, single read port ram with registered read
// no dependencies
module nmed_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/nmed_fifo.sv
// nmed_fifo: small register queue with push/full and pop/empty sides
// no dependencies
module nmed_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill above depth");

endmodule

// File: src/nmed_front.sv
// nmed_front: frame registers, raster position, two line buffers and operand gathering
// depends on nmed_pkg and nmed_ram
module nmed_front #(
   parameter int MAX_COLS   = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  nmed_pkg::nmed_csr_type               csr_index,
   input  logic [nmed_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [PIXEL_BITS-1:0]         req_pixel,
   output logic                                 q_push,
   input  logic                                 q_full,
   output nmed_pkg::nmed_tag_type               q_tag,
   output logic [6*(PIXEL_BITS+2)-1:0]          q_sums
);

   localparam int AW = $clog2(MAX_COLS);
   localparam int SW = PIXEL_BITS + 2;

   // frame registers and position
   logic [nmed_pkg::ROWS_CFG_BITS-1:0] frame_rows_ff, frame_rows_in;
   logic [nmed_pkg::COLS_CFG_BITS-1:0] frame_cols_ff, frame_cols_in;
   logic [nmed_pkg::ROW_BITS-1:0]      row_ff, row_in;
   logic [AW-1:0]                      col_ff, col_in;
   logic                               sel_ff, sel_in;
   logic [PIXEL_BITS-1:0]              prev_ff, prev_in;
   logic [PIXEL_BITS-1:0]              prev2_ff, prev2_in;

   logic [nmed_pkg::ROW_BITS-1:0] rows_last;
   logic [AW-1:0]                 cols_last;
   logic [AW-1:0]                 col_plus;
   logic                          accept, s1_go, last_col, last_row;

   // operand stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [PIXEL_BITS-1:0]  s1_pixel_ff, s1_prev_ff, s1_prev2_ff;
   logic                   s1_sel_ff, s1_c0_ff, s1_c1_ff, s1_c2_ff, s1_r2_ff, s1_lc_ff;
   nmed_pkg::nmed_tag_type s1_tag_ff, tag_in;

   // window over the row above
   logic [PIXEL_BITS-1:0] first_ff, first_in;
   logic [PIXEL_BITS-1:0] mid_ff, mid_in;
   logic [PIXEL_BITS-1:0] left_ff, left_in;

   logic [PIXEL_BITS-1:0] rd0, rd1, above_c, above_cp1, two_above;
   logic [AW-1:0]         rd_addr0, rd_addr1;

   logic signed [SW-1:0] px, prev_x, prev2_x, ac_x, am1_x, ap1_x, two_x;
   logic signed [SW-1:0] sum_u, sc_u, sum_l, sc_l, sum_c, sc_c;
   logic [1:0]           nb_extra;

   // effective frame size
   always_comb begin
      if (frame_rows_ff < nmed_pkg::ROWS_CFG_BITS'(2)) begin
         rows_last = nmed_pkg::ROW_BITS'(1);
      end else begin
         rows_last = frame_rows_ff - nmed_pkg::ROWS_CFG_BITS'(1);
      end
      if (frame_cols_ff < nmed_pkg::COLS_CFG_BITS'(2)) begin
         cols_last = AW'(1);
      end else if (32'(frame_cols_ff) > 32'(MAX_COLS)) begin
         cols_last = AW'(MAX_COLS - 1);
      end else begin
         cols_last = AW'(frame_cols_ff - nmed_pkg::COLS_CFG_BITS'(1));
      end
   end

   assign s1_go    = s1_valid_ff && !q_full;
   assign req_full = s1_valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign last_col = (col_ff == cols_last);
   assign last_row = (row_ff == rows_last);
   assign col_plus = col_ff + AW'(1);

   always_comb begin
      frame_rows_in = frame_rows_ff;
      frame_cols_in = frame_cols_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      sel_in        = sel_ff;
      prev_in       = prev_ff;
      prev2_in      = prev2_ff;
      if (csr_wr_en) begin
         case (csr_index)
            nmed_pkg::CSR_FRAME_ROWS: begin
               frame_rows_in = csr_wdata[nmed_pkg::ROWS_CFG_BITS-1:0];
            end
            nmed_pkg::CSR_FRAME_COLS: begin
               frame_cols_in = csr_wdata[nmed_pkg::COLS_CFG_BITS-1:0];
            end
            default: begin
            end
         endcase
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         prev_in  = req_pixel;
         prev2_in = prev_ff;
         if (last_col) begin
            col_in = '0;
            sel_in = !sel_ff;
            row_in = last_row ? '0 : row_ff + nmed_pkg::ROW_BITS'(1);
         end else begin
            col_in = col_plus;
         end
      end
   end

   always_comb begin
      tag_in.row        = row_ff;
      tag_in.col        = nmed_pkg::COL_BITS'(col_ff);
      tag_in.up_cell    = (row_ff != '0);
      tag_in.low_left   = last_row && (col_ff != '0);
      tag_in.low_corner = last_row && last_col;
      s1_valid_in       = accept || (s1_valid_ff && !s1_go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff <= nmed_pkg::ROWS_CFG_BITS'(2);
         frame_cols_ff <= nmed_pkg::COLS_CFG_BITS'(2);
         row_ff        <= '0;
         col_ff        <= '0;
         sel_ff        <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else begin
         frame_rows_ff <= frame_rows_in;
         frame_cols_ff <= frame_cols_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         sel_ff        <= sel_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff  <= prev_in;
      prev2_ff <= prev2_in;
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_prev_ff  <= prev_ff;
         s1_prev2_ff <= prev2_ff;
         s1_sel_ff   <= sel_ff;
         s1_c0_ff    <= (col_ff == '0);
         s1_c1_ff    <= (col_ff != '0);
         s1_c2_ff    <= (col_ff > AW'(1));
         s1_r2_ff    <= (row_ff > nmed_pkg::ROW_BITS'(1));
         s1_lc_ff    <= last_col;
         s1_tag_ff   <= tag_in;
      end
      first_ff <= first_in;
      mid_ff   <= mid_in;
      left_ff  <= left_in;
   end

   // bank selected by sel holds the row above, the other the row two above
   assign rd_addr0 = sel_ff ? col_ff : col_plus;
   assign rd_addr1 = sel_ff ? col_plus : col_ff;

   nmed_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_COLS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (accept && sel_ff),
      .wr_addr (col_ff),
      .wr_data (req_pixel),
      .rd_en   (accept),
      .rd_addr (rd_addr0),
      .rd_data (rd0)
   );

   nmed_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_COLS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (accept && !sel_ff),
      .wr_addr (col_ff),
      .wr_data (req_pixel),
      .rd_en   (accept),
      .rd_addr (rd_addr1),
      .rd_data (rd1)
   );

   assign above_cp1 = s1_sel_ff ? rd1 : rd0;
   assign two_above = s1_sel_ff ? rd0 : rd1;
   assign above_c   = s1_c0_ff ? first_ff : mid_ff;

   always_comb begin
      first_in = first_ff;
      mid_in   = mid_ff;
      left_in  = left_ff;
      if (s1_go) begin
         mid_in  = above_cp1;
         left_in = above_c;
         if (s1_c0_ff) begin
            first_in = s1_pixel_ff;
         end
      end
   end

   assign px      = {{2{s1_pixel_ff[PIXEL_BITS-1]}}, s1_pixel_ff};
   assign prev_x  = {{2{s1_prev_ff[PIXEL_BITS-1]}}, s1_prev_ff};
   assign prev2_x = {{2{s1_prev2_ff[PIXEL_BITS-1]}}, s1_prev2_ff};
   assign ac_x    = {{2{above_c[PIXEL_BITS-1]}}, above_c};
   assign am1_x   = {{2{left_ff[PIXEL_BITS-1]}}, left_ff};
   assign ap1_x   = {{2{above_cp1[PIXEL_BITS-1]}}, above_cp1};
   assign two_x   = {{2{two_above[PIXEL_BITS-1]}}, two_above};

   assign nb_extra = 2'(s1_r2_ff) + 2'(s1_c1_ff) + 2'(!s1_lc_ff);

   always_comb begin
      // cell above, neighbours below, two above, left and right
      sum_u = px + (s1_r2_ff ? two_x : '0) + (s1_c1_ff ? am1_x : '0)
            + (s1_lc_ff ? '0 : ap1_x);
      case (nb_extra)
         2'd1:    sc_u = ac_x + ac_x;
         2'd2:    sc_u = ac_x + (ac_x <<< 1);
         2'd3:    sc_u = ac_x <<< 2;
         default: sc_u = ac_x;
      endcase
      // bottom row cell to the left
      sum_l = px + am1_x + (s1_c2_ff ? prev2_x : '0);
      sc_l  = s1_c2_ff ? prev_x + (prev_x <<< 1) : prev_x + prev_x;
      // bottom right corner
      sum_c = prev_x + ac_x;
      sc_c  = px + px;
   end

   assign q_push = s1_go;
   assign q_tag  = s1_tag_ff;
   assign q_sums = {sum_u, sc_u, sum_l, sc_l, sum_c, sc_c};

   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && q_full |=> s1_valid_ff && $stable(s1_tag_ff))
      else $error("operand stage lost a request while stalled");

endmodule

// File: src/nmed_back.sv
// nmed_back: equality tests, match total and serialising of results
// depends on nmed_pkg
module nmed_back #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic                           q_empty,
   output logic                           q_pop,
   input  nmed_pkg::nmed_tag_type         q_tag,
   input  logic [6*(PIXEL_BITS+2)-1:0]    q_sums,
   output logic                           res_push,
   input  logic                           res_full,
   output nmed_pkg::nmed_rsp_type         res
);

   localparam int SW = PIXEL_BITS + 2;

   logic [SW-1:0] sum_u, sc_u, sum_l, sc_l, sum_c, sc_c;
   logic [nmed_pkg::RES_KINDS-1:0] head_mask;

   logic                                cur_valid_ff, cur_valid_in;
   logic [nmed_pkg::RES_KINDS-1:0]      cur_mask_ff, cur_mask_in;
   nmed_pkg::nmed_tag_type              cur_tag_ff, cur_tag_in;
   logic [nmed_pkg::TOTAL_BITS-1:0]     tot_ff, tot_in;

   logic [nmed_pkg::RES_KINDS-1:0] lowest, rest;
   logic                           emit, finish, load;

   assign {sum_u, sc_u, sum_l, sc_l, sum_c, sc_c} = q_sums;

   always_comb begin
      head_mask                      = '0;
      head_mask[nmed_pkg::RES_UP]     = q_tag.up_cell && (sum_u == sc_u);
      head_mask[nmed_pkg::RES_LEFT]   = q_tag.low_left && (sum_l == sc_l);
      head_mask[nmed_pkg::RES_CORNER] = q_tag.low_corner && (sum_c == sc_c);
      head_mask[nmed_pkg::RES_TOTAL]  = q_tag.low_corner;
   end

   assign lowest = cur_mask_ff & (~cur_mask_ff + nmed_pkg::RES_KINDS'(1));
   assign rest   = cur_mask_ff & ~lowest;
   assign emit   = cur_valid_ff && (cur_mask_ff != '0) && !res_full;
   assign finish = cur_valid_ff && ((cur_mask_ff == '0) || (emit && (rest == '0)));
   assign load   = !q_empty && (!cur_valid_ff || finish);
   assign q_pop  = load;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_mask_in  = cur_mask_ff;
      cur_tag_in   = cur_tag_ff;
      tot_in       = tot_ff;
      if (load) begin
         cur_valid_in = 1'b1;
         cur_mask_in  = head_mask;
         cur_tag_in   = q_tag;
      end else if (finish) begin
         cur_valid_in = 1'b0;
         cur_mask_in  = '0;
      end else if (emit) begin
         cur_mask_in = rest;
      end
      if (clear) begin
         tot_in = '0;
      end else if (emit) begin
         tot_in = lowest[nmed_pkg::RES_TOTAL] ? '0 : tot_ff + nmed_pkg::TOTAL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_mask_ff  <= '0;
         tot_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         cur_mask_ff  <= cur_mask_in;
         tot_ff       <= tot_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_tag_ff <= cur_tag_in;
   end

   always_comb begin
      res          = '0;
      res.last     = (rest == '0);
      if (lowest[nmed_pkg::RES_UP]) begin
         res.row = cur_tag_ff.row - nmed_pkg::ROW_BITS'(1);
         res.col = cur_tag_ff.col;
      end else if (lowest[nmed_pkg::RES_LEFT]) begin
         res.row = cur_tag_ff.row;
         res.col = cur_tag_ff.col - nmed_pkg::COL_BITS'(1);
      end else if (lowest[nmed_pkg::RES_CORNER]) begin
         res.row = cur_tag_ff.row;
         res.col = cur_tag_ff.col;
      end else begin
         res.is_total = 1'b1;
         res.total    = tot_ff;
      end
   end

   assign res_push = emit;

   a_one_kind : assert property (@(posedge clock) disable iff (reset)
      emit |-> $onehot(lowest))
      else $error("more than one result kind chosen");

   a_total_last : assert property (@(posedge clock) disable iff (reset)
      res_push && res.is_total |-> res.last)
      else $error("frame total not the last result of its request");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      emit && !lowest[nmed_pkg::RES_TOTAL] && !clear
      |=> tot_ff == $past(tot_ff) + nmed_pkg::TOTAL_BITS'(1))
      else $error("match total not advanced on a match");

endmodule

// File: src/neighbor_mean_equality_detector.sv
// neighbor_mean_equality_detector: top level, front end, request queue, back end, result queue
// depends on nmed_pkg, nmed_fifo, nmed_front, nmed_back (and nmed_ram below the front)
//
//   channel   direction  handshake               payload
//   req       in         req_push / req_full     req_pixel
//   rsp       out        rsp_pop / rsp_empty     rsp_row, rsp_col, rsp_is_total, rsp_total, rsp_last
//   csr       in         csr_wr_en               csr_index, csr_wdata
//
// one pixel per cycle while req_full is low; the back end sends the results of a pixel one at a time
// (only pixels of the last row give more than one), set by the single result write port
// the first result passes the operand stage, the request queue, the back end and the result queue
// reset is synchronous; frame size returns to 2 x 2, line buffers are not cleared
// req_full rises when the operand stage holds a request and the four-entry queue is full
module neighbor_mean_equality_detector #(
   parameter int MAX_COLS   = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  nmed_pkg::nmed_csr_type               csr_index,
   input  logic [nmed_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [PIXEL_BITS-1:0]         req_pixel,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [nmed_pkg::ROW_BITS-1:0]        rsp_row,
   output logic [nmed_pkg::COL_BITS-1:0]        rsp_col,
   output logic                                 rsp_is_total,
   output logic [nmed_pkg::TOTAL_BITS-1:0]      rsp_total,
   output logic                                 rsp_last
);

   localparam int SW    = PIXEL_BITS + 2;
   localparam int MID_W = $bits(nmed_pkg::nmed_tag_type) + 6 * SW;
   localparam int RSP_W = $bits(nmed_pkg::nmed_rsp_type);

   logic                   fq_push, fq_full, bq_empty, bq_pop;
   nmed_pkg::nmed_tag_type fq_tag, bq_tag;
   logic [6*SW-1:0]        fq_sums, bq_sums;
   logic [MID_W-1:0]       bq_data;

   logic                   res_push, res_full;
   nmed_pkg::nmed_rsp_type res, rsp_head;
   logic [RSP_W-1:0]       rsp_data;

   nmed_front #(
      .MAX_COLS   (MAX_COLS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_pixel (req_pixel),
      .q_push    (fq_push),
      .q_full    (fq_full),
      .q_tag     (fq_tag),
      .q_sums    (fq_sums)
   );

   nmed_fifo #(
      .WIDTH (MID_W),
      .DEPTH (4)
   ) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .push    (fq_push),
      .full    (fq_full),
      .wr_data ({fq_tag, fq_sums}),
      .pop     (bq_pop),
      .empty   (bq_empty),
      .rd_data (bq_data)
   );

   assign {bq_tag, bq_sums} = bq_data;

   nmed_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .clear    (csr_wr_en),
      .q_empty  (bq_empty),
      .q_pop    (bq_pop),
      .q_tag    (bq_tag),
      .q_sums   (bq_sums),
      .res_push (res_push),
      .res_full (res_full),
      .res      (res)
   );

   nmed_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (4)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .full    (res_full),
      .wr_data (res),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_data)
   );

   assign rsp_head     = nmed_pkg::nmed_rsp_type'(rsp_data);
   assign rsp_row      = rsp_head.row;
   assign rsp_col      = rsp_head.col;
   assign rsp_is_total = rsp_head.is_total;
   assign rsp_total    = rsp_head.total;
   assign rsp_last     = rsp_head.last;

endmodule
